/* rtl/occ_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_MAP_CELLS  = 65536;
    localparam int DEF_MAX_RADIUS = 8;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;

    // Occupancy codes.
    localparam logic [7:0] OBSTACLE_CODE = 8'h64;
    localparam logic [7:0] UNKNOWN_CODE  = 8'hFF;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register reset values.
    localparam logic [15:0] RST_INV_RES = 16'd1024;
    localparam logic [23:0] RST_ORIGIN  = 24'd0;
    localparam logic [15:0] RST_WIDTH   = 16'd256;
    localparam logic [15:0] RST_HEIGHT  = 16'd256;
    localparam logic [3:0]  RST_RADIUS  = 4'd1;
    localparam logic        RST_UNK     = 1'b1;

    typedef enum logic [2:0] {
        CFG_INV_RES  = 3'd0,
        CFG_ORIGIN_X = 3'd1,
        CFG_ORIGIN_Y = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4,
        CFG_RADIUS   = 3'd5,
        CFG_UNK_FREE = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0]        inv_res;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [3:0]         radius;
        logic               unk_free;
    } t_cfg;

    // What the back has to do with one queued word.
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_NOMAP = 2'd1,
        K_OFF   = 2'd2,
        K_SCAN  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] idx;
        logic [7:0]  val;
        logic [15:0] cx;
        logic [15:0] cy;
    } t_qent;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ABS,
        F_PUSH
    } t_fst;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_BACK,
        B_SCAN,
        B_DRAIN,
        B_EMIT
    } t_bst;

endpackage

`default_nettype wire

/* rtl/occ_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module occ_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire occ_pkg::t_cfg       i_cfg,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_cmd,
    input  wire logic [15:0]         i_idx,
    input  wire logic [7:0]          i_val,
    input  wire logic signed [23:0]  i_qx,
    input  wire logic signed [23:0]  i_qy,
    input  wire logic                i_full,
    output logic                     o_push,
    output occ_pkg::t_qent           o_entry
);
    import occ_pkg::*;

    t_fst r_state, n_state;
    logic r_loaded;

    logic               r_cmd;
    logic [15:0]        r_idx;
    logic [7:0]         r_val;
    logic signed [24:0] r_dx, r_dy;
    logic signed [41:0] r_px, r_py;
    logic               r_negx, r_negy;
    logic [25:0]        r_magx, r_magy;

    logic signed [41:0] w_absx, w_absy;
    logic               w_onx, w_ony;
    logic               w_accept;

    assign w_accept = i_valid && o_ready;
    assign w_absx = r_px[41] ? -r_px : r_px;
    assign w_absy = r_py[41] ? -r_py : r_py;

    // A negative cell that truncates to zero is still on the map.
    assign w_onx = (!r_negx || (r_magx == 26'd0)) && (r_magx < {10'd0, i_cfg.width});
    assign w_ony = (!r_negy || (r_magy == 26'd0)) && (r_magy < {10'd0, i_cfg.height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_loaded <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_push && (r_cmd == CMD_WRITE)) begin
                r_loaded <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = (i_cmd == CMD_WRITE) ? F_PUSH : F_MUL;
                end
            end
            F_MUL: n_state = F_ABS;
            F_ABS: n_state = F_PUSH;
            F_PUSH: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_idx <= i_idx;
            r_val <= i_val;
            r_dx  <= $signed({i_qx[23], i_qx}) - $signed({i_cfg.origin_x[23], i_cfg.origin_x});
            r_dy  <= $signed({i_qy[23], i_qy}) - $signed({i_cfg.origin_y[23], i_cfg.origin_y});
        end
        if (r_state == F_MUL) begin
            r_px <= r_dx * $signed({1'b0, i_cfg.inv_res});
            r_py <= r_dy * $signed({1'b0, i_cfg.inv_res});
        end
        if (r_state == F_ABS) begin
            r_negx <= r_px[41];
            r_negy <= r_py[41];
            r_magx <= w_absx[41:16];
            r_magy <= w_absy[41:16];
        end
    end

    always_comb begin
        o_entry.idx = r_idx;
        o_entry.val = r_val;
        o_entry.cx  = r_magx[15:0];
        o_entry.cy  = r_magy[15:0];
        if (r_cmd == CMD_WRITE) begin
            o_entry.kind = K_WRITE;
        end else if (!r_loaded) begin
            o_entry.kind = K_NOMAP;
        end else if (w_onx && w_ony) begin
            o_entry.kind = K_SCAN;
        end else begin
            o_entry.kind = K_OFF;
        end
    end

endmodule

`default_nettype wire

/* rtl/occ_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module occ_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire occ_pkg::t_qent i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output occ_pkg::t_qent      o_data,
    output logic                o_empty
);
    import occ_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    t_qent          r_buf [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/occ_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module occ_back #(
    parameter int MAP_CELLS  = occ_pkg::DEF_MAP_CELLS,
    parameter int MAX_RADIUS = occ_pkg::DEF_MAX_RADIUS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire occ_pkg::t_cfg  i_cfg,
    input  wire logic           i_empty,
    input  wire occ_pkg::t_qent i_data,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic                o_free
);
    import occ_pkg::*;

    localparam int AW = $clog2(MAP_CELLS);
    localparam int RW = $clog2(MAX_RADIUS + 2);
    localparam int CW = $clog2(2 * MAX_RADIUS + 2);
    localparam logic [AW:0] MC1 = (AW+1)'(MAP_CELLS);

    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MC1) begin
            s = s - MC1;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] mod_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            s = s + MC1;
        end
        return s[AW-1:0];
    endfunction

    t_bst r_state, n_state;
    logic r_out_valid, r_rd_v;

    logic [7:0]         r_cell_mem [MAP_CELLS];
    logic [7:0]         r_mem_q;
    logic               r_rd_on;
    logic               r_free;
    logic               r_blocked;
    logic [15:0]        r_cx, r_cy;
    logic [RW-1:0]      r_rad;
    logic [AW-1:0]      r_wmod, r_lin, r_row_lin;
    logic [CW-1:0]      r_bcnt, r_ix, r_iy;
    logic signed [17:0] r_nx, r_ny;

    logic          w_we, w_re, w_load_out, w_out_val;
    logic [31:0]   w_idx32;
    logic          w_idx_ok;
    logic [AW-1:0] w_waddr;
    logic [RW-1:0] w_rad;
    logic [CW-1:0] w_span;
    logic [31:0]   w_width32, w_base;
    logic          w_col_end, w_row_end;
    logic          w_onmap, w_hit;
    logic [AW-1:0] w_row_next, w_back_dec;

    assign w_idx32  = {16'd0, i_data.idx};
    assign w_idx_ok = (w_idx32 < 32'(MAP_CELLS));
    assign w_waddr  = w_idx32[AW-1:0];

    assign w_rad  = (32'(i_cfg.radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(i_cfg.radius);
    assign w_span = CW'({r_rad, 1'b0});

    // The map size is a power of two, so the address wrap keeps the low bits.
    assign w_width32 = {16'd0, i_cfg.width};
    assign w_base    = ({16'd0, r_cy} * w_width32) + {16'd0, r_cx};

    assign w_col_end  = (r_ix == w_span);
    assign w_row_end  = (r_iy == w_span);
    assign w_row_next = mod_add(r_row_lin, r_wmod);
    assign w_back_dec = (CW'(r_rad) > r_bcnt) ? r_wmod : AW'(1);

    assign w_onmap = !r_nx[17] && !r_ny[17]
                     && (r_nx < $signed({2'b00, i_cfg.width}))
                     && (r_ny < $signed({2'b00, i_cfg.height}));

    assign w_hit = r_rd_v && (r_rd_on
                   ? ((r_mem_q == OBSTACLE_CODE) || ((r_mem_q == UNKNOWN_CODE) && !i_cfg.unk_free))
                   : !i_cfg.unk_free);

    assign o_tvalid = r_out_valid;
    assign o_free   = r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_re;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_load_out = 1'b0;
        w_out_val  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty && !r_out_valid) begin
                    o_pop = 1'b1;
                    case (i_data.kind)
                        K_WRITE: w_we = w_idx_ok;
                        K_NOMAP: w_load_out = 1'b1;
                        K_OFF: begin
                            w_load_out = 1'b1;
                            w_out_val  = i_cfg.unk_free;
                        end
                        K_SCAN:  n_state = B_MUL;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_MUL: n_state = B_BACK;
            B_BACK: begin
                if (r_bcnt == w_span) begin
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                w_re = 1'b1;
                if (w_col_end && w_row_end) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: n_state = B_EMIT;
            B_EMIT: begin
                w_load_out = 1'b1;
                w_out_val  = !r_blocked;
                n_state    = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cell_mem[w_waddr] <= i_data.val;
        end
        if (w_re) begin
            r_mem_q <= r_cell_mem[r_lin];
        end
    end

    // Addresses are kept modulo the map size: the window corner is reached by
    // stepping back from the center, and the row base advances by width.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_free <= w_out_val;
        end
        r_rd_on <= w_onmap;
        case (r_state)
            B_IDLE: begin
                if (o_pop && (i_data.kind == K_SCAN)) begin
                    r_cx  <= i_data.cx;
                    r_cy  <= i_data.cy;
                    r_rad <= w_rad;
                end
            end
            B_MUL: begin
                r_lin  <= w_base[AW-1:0];
                r_wmod <= w_width32[AW-1:0];
                r_bcnt <= '0;
            end
            B_BACK: begin
                if (r_bcnt == w_span) begin
                    r_row_lin <= r_lin;
                    r_nx      <= $signed({2'b00, r_cx}) - $signed(18'(r_rad));
                    r_ny      <= $signed({2'b00, r_cy}) - $signed(18'(r_rad));
                    r_ix      <= '0;
                    r_iy      <= '0;
                    r_blocked <= 1'b0;
                end else begin
                    r_lin  <= mod_sub(r_lin, w_back_dec);
                    r_bcnt <= r_bcnt + 1'b1;
                end
            end
            B_SCAN: begin
                if (w_col_end) begin
                    r_ix      <= '0;
                    r_iy      <= r_iy + 1'b1;
                    r_nx      <= $signed({2'b00, r_cx}) - $signed(18'(r_rad));
                    r_ny      <= r_ny + 18'sd1;
                    r_row_lin <= w_row_next;
                    r_lin     <= w_row_next;
                end else begin
                    r_ix  <= r_ix + 1'b1;
                    r_nx  <= r_nx + 18'sd1;
                    r_lin <= mod_add(r_lin, AW'(1));
                end
            end
            default: begin
            end
        endcase
        if (r_rd_v) begin
            r_blocked <= r_blocked | w_hit;
        end
    end

endmodule

`default_nettype wire

/* rtl/occupancy_grid_footprint_check_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: index, value, x, y
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: point_free
// cfg       in   i_cfg_we                     i_cfg_idx register, i_cfg_data value
//
// A cell write is stored when the back pops it. A query passes F_MUL and F_ABS in
// the front; the back then steps to the window corner and reads the (2r+1)^2 cells
// of a footprint of radius r on the map through the single cell memory read port;
// an off-map or pre-load query is answered on pop. MAP_CELLS is a power of two.
// Reset needs no clearing pass; the cell store is undefined until written.
// A stalled result holds in the output register while the front fills the queue.
module occupancy_grid_footprint_check_core #(
    parameter int MAP_CELLS  = occ_pkg::DEF_MAP_CELLS,
    parameter int MAX_RADIUS = occ_pkg::DEF_MAX_RADIUS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // cell_index[15:0], cell_value[23:16],
                                             // query_x[47:24], query_y[71:48]
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // point_free[0], zeros above
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    import occ_pkg::*;

    t_cfg  r_cfg;
    t_qent w_push_data, w_pop_data;
    logic  w_push, w_full, w_pop, w_empty, w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_res  <= RST_INV_RES;
            r_cfg.origin_x <= RST_ORIGIN;
            r_cfg.origin_y <= RST_ORIGIN;
            r_cfg.width    <= RST_WIDTH;
            r_cfg.height   <= RST_HEIGHT;
            r_cfg.radius   <= RST_RADIUS;
            r_cfg.unk_free <= RST_UNK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_RES:  r_cfg.inv_res  <= i_cfg_data[15:0];
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data;
                CFG_WIDTH:    r_cfg.width    <= i_cfg_data[15:0];
                CFG_HEIGHT:   r_cfg.height   <= i_cfg_data[15:0];
                CFG_RADIUS:   r_cfg.radius   <= i_cfg_data[3:0];
                CFG_UNK_FREE: r_cfg.unk_free <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    occ_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_idx   (s_axis_tdata[15:0]),
        .i_val   (s_axis_tdata[23:16]),
        .i_qx    (s_axis_tdata[47:24]),
        .i_qy    (s_axis_tdata[71:48]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_data)
    );

    occ_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    occ_back #(
        .MAP_CELLS  (MAP_CELLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_data   (w_pop_data),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_free   (w_free)
    );

    assign m_axis_tdata = {7'd0, w_free};

endmodule

`default_nettype wire

/* rtl/occ_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module occ_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    logic       r_loaded;
    logic [7:0] r_pending;
    logic [7:0] r_pre;
    logic       w_in_q, w_in_w, w_out;

    assign w_in_q = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign w_in_w = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
    assign w_out  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= 1'b0;
            r_pending <= '0;
            r_pre     <= '0;
        end else begin
            if (w_in_w) begin
                r_loaded <= 1'b1;
            end
            r_pending <= r_pending + {7'd0, w_in_q} - {7'd0, w_out};
            r_pre <= r_pre + {7'd0, w_in_q && !r_loaded} - {7'd0, w_out && (r_pre != 8'd0)};
        end
    end

    // The result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Every word on the result side answers an earlier query.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 8'd0))
        else $error("result without a pending query");

    // Queries taken before the first cell write answer blocked.
    a_unloaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_pre != 8'd0)) |-> (m_axis_tdata[0] == 1'b0))
        else $error("query before load answered free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind occupancy_grid_footprint_check_core occ_chk u_occ_chk (.*);

`default_nettype wire
